// ===== rtl/core/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// Plane RLE decoder package
// Shared widths, constants, phase codes and the result and queue types.
// ----------------------------------------------------------------------------
package prd_pkg;

   localparam int BYTE_W  = 8;
   localparam int REP_W   = 21;
   localparam int ACC_W   = 32;
   localparam int SEEN_W  = 2;

   localparam logic [REP_W-1:0] PLANE_BYTES_MAX = REP_W'(1048576);
   localparam logic [REP_W-1:0] RESET_SIZE      = REP_W'(4);
   localparam logic [REP_W-1:0] RAW_LEFT        = REP_W'(4);
   localparam logic [REP_W-1:0] PRE_RAW_LEFT    = REP_W'(5);
   localparam logic [BYTE_W-1:0] ESC_BYTE       = 8'hFF;
   localparam logic [ACC_W-1:0] SHORT_BIAS      = ACC_W'(2);
   localparam logic [SEEN_W-1:0] SEEN_LAST      = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic [2:0] {
      PH_VALUE,
      PH_SECOND,
      PH_LEN_SHORT,
      PH_LEN_LONG,
      PH_RAW,
      PH_DONE,
      PH_FAILED,
      PH_BADSIZE
   } prd_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [REP_W-1:0]  repeat_res;
      logic              last;
      logic              error;
   } prd_result_type;

   // Up to two results per coded byte go into the queue in the same cycle
   typedef struct packed {
      logic [1:0]     count;
      prd_result_type item0;
      prd_result_type item1;
   } prd_push_type;

   typedef struct packed {
      logic           valid;
      prd_result_type item;
   } prd_head_type;

   localparam prd_result_type ERR_RESULT = '{out_byte: '0, repeat_res: '0,
                                             last: 1'b0, error: 1'b1};

   function automatic prd_result_type single_result(input logic [BYTE_W-1:0] b,
                                                    input logic last_flag);
      prd_result_type r;
      r.out_byte   = b;
      r.repeat_res = REP_W'(1);
      r.last       = last_flag;
      r.error      = 1'b0;
      return r;
   endfunction

   function automatic prd_phase_type start_phase(input logic [REP_W-1:0] size);
      prd_phase_type p;
      if (size < RAW_LEFT) begin
         p = PH_BADSIZE;
      end else if (size == RAW_LEFT) begin
         p = PH_RAW;
      end else begin
         p = PH_VALUE;
      end
      return p;
   endfunction

endpackage

// ===== rtl/core/prd_ifs.sv =====
// ----------------------------------------------------------------------------
// Plane RLE decoder channels
// Coded byte input, decoded result output and size register write channel.
// ----------------------------------------------------------------------------
interface prd_req_if import prd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] coded_byte;
   logic              final_req;
   modport source (output valid, coded_byte, final_req, input ready);
   modport sink   (input valid, coded_byte, final_req, output ready);
endinterface

interface prd_rsp_if import prd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic [REP_W-1:0]  repeat_res;
   logic              last;
   logic              error;
   modport source (output valid, out_byte, repeat_res, last, error, input ready);
   modport sink   (input valid, out_byte, repeat_res, last, error, output ready);
endinterface

interface prd_csr_if import prd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REP_W-1:0] original_size;
   modport source (output valid, original_size, input ready);
   modport sink   (input valid, original_size, output ready);
endinterface

// ===== rtl/core/prd_front.sv =====
// ----------------------------------------------------------------------------
// Plane RLE decoder front end
// Takes one coded byte per cycle while room is set, tracks the decode phase
// and pushes the zero, one or two results each byte yields into the queue.
// ----------------------------------------------------------------------------
module prd_front import prd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   prd_req_if.sink      req_ch,
   prd_csr_if.sink      csr_ch,
   input  logic         room,
   output prd_push_type push
);

   prd_phase_type      phase_ff, phase_in;
   logic [BYTE_W-1:0]  held_ff, held_in;
   logic [REP_W-1:0]   remaining_ff, remaining_in;
   logic [ACC_W-1:0]   accum_ff, accum_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;

   logic               accept;
   logic [BYTE_W-1:0]  b;
   logic [ACC_W-1:0]   accum_new;
   logic [ACC_W-1:0]   run_len;
   logic [REP_W-1:0]   rem_m1;
   logic [REP_W-1:0]   rem_after;
   logic               too_long;
   logic               run_go;
   logic [REP_W-1:0]   size_sat;

   assign req_ch.ready = room;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid & room;
   assign b            = req_ch.coded_byte;

   assign size_sat  = (csr_ch.original_size > PLANE_BYTES_MAX) ? PLANE_BYTES_MAX
                                                               : csr_ch.original_size;
   assign accum_new = accum_ff | (ACC_W'(b) << {seen_ff, 3'b000});
   assign run_len   = (phase_ff == PH_LEN_SHORT) ? (ACC_W'(b) + SHORT_BIAS) : accum_new;
   assign too_long  = run_len > ACC_W'(remaining_ff);
   assign rem_after = remaining_ff - run_len[REP_W-1:0];
   assign rem_m1    = remaining_ff - REP_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      held_in      = held_ff;
      remaining_in = remaining_ff;
      accum_in     = accum_ff;
      seen_in      = seen_ff;
      push         = '0;
      run_go       = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_BADSIZE: begin
               phase_in   = PH_FAILED;
               push.count = 2'd1;
               push.item0 = ERR_RESULT;
            end
            PH_VALUE: begin
               if (remaining_ff == PRE_RAW_LEFT) begin
                  push.count   = 2'd1;
                  push.item0   = single_result(b, 1'b0);
                  remaining_in = RAW_LEFT;
                  phase_in     = PH_RAW;
               end else begin
                  held_in  = b;
                  phase_in = PH_SECOND;
               end
            end
            PH_SECOND: begin
               if (b == held_ff) begin
                  phase_in = PH_LEN_SHORT;
               end else begin
                  push.count   = 2'd1;
                  push.item0   = single_result(held_ff, 1'b0);
                  remaining_in = rem_m1;
                  if (rem_m1 == PRE_RAW_LEFT) begin
                     push.count   = 2'd2;
                     push.item1   = single_result(b, 1'b0);
                     remaining_in = RAW_LEFT;
                     phase_in     = PH_RAW;
                  end else begin
                     held_in = b;
                  end
               end
            end
            PH_LEN_SHORT: begin
               if (b != ESC_BYTE) begin
                  run_go = 1'b1;
               end else begin
                  accum_in = '0;
                  seen_in  = '0;
                  phase_in = PH_LEN_LONG;
               end
            end
            PH_LEN_LONG: begin
               accum_in = accum_new;
               if (seen_ff == SEEN_LAST) begin
                  seen_in = '0;
                  run_go  = 1'b1;
               end else begin
                  seen_in = seen_ff + SEEN_W'(1);
               end
            end
            PH_RAW: begin
               remaining_in = REP_W'(rem_m1[1:0]);
               push.count   = 2'd1;
               push.item0   = single_result(b, rem_m1[1:0] == 2'd0);
               if (rem_m1[1:0] == 2'd0) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               // done or failed: drop the byte
            end
         endcase

         if (run_go) begin
            if (too_long) begin
               phase_in   = PH_FAILED;
               push.count = 2'd1;
               push.item0 = ERR_RESULT;
            end else begin
               if (run_len != '0) begin
                  push.count            = 2'd1;
                  push.item0.out_byte   = held_ff;
                  push.item0.repeat_res = run_len[REP_W-1:0];
                  push.item0.last       = 1'b0;
                  push.item0.error      = 1'b0;
               end
               remaining_in = rem_after;
               if (rem_after > RAW_LEFT) begin
                  phase_in = PH_VALUE;
               end else if (rem_after == RAW_LEFT) begin
                  phase_in = PH_RAW;
               end else begin
                  phase_in   = PH_FAILED;
                  push.count = 2'd1;
                  push.item0 = ERR_RESULT;
               end
            end
         end

         // Stream ended short of the plane: replace whatever this byte gave
         if (req_ch.final_req && phase_in != PH_DONE && phase_in != PH_FAILED) begin
            phase_in   = PH_FAILED;
            push.count = 2'd1;
            push.item0 = ERR_RESULT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= start_phase(RESET_SIZE);
         held_ff      <= '0;
         remaining_ff <= RESET_SIZE;
         accum_ff     <= '0;
         seen_ff      <= '0;
      end else if (csr_ch.valid) begin
         phase_ff     <= start_phase(size_sat);
         held_ff      <= '0;
         remaining_ff <= size_sat;
         accum_ff     <= '0;
         seen_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         remaining_ff <= remaining_in;
         accum_ff     <= accum_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

// ===== rtl/core/prd_queue.sv =====
// ----------------------------------------------------------------------------
// Plane RLE decoder result queue
// Small FIFO between front and back: up to two words in, one word out.
// ----------------------------------------------------------------------------
module prd_queue import prd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  prd_push_type push,
   output logic         room,
   input  logic         pop,
   output prd_head_type head
);

   prd_result_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   // Front may push two words, so keep two slots free before accepting
   assign room       = cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign head.valid = cnt_ff != '0;
   assign head.item  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + QPTR_W'(push.count);
      rd_in  = rd_ff + QPTR_W'(pop);
      cnt_in = cnt_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + QPTR_W'(1)] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/prd_back.sv =====
// ----------------------------------------------------------------------------
// Plane RLE decoder back end
// Output register: takes the queue head and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module prd_back import prd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  prd_head_type head,
   output logic         pop,
   prd_rsp_if.source    rsp_ch
);

   logic           valid_ff, valid_in;
   prd_result_type out_ff;

   // Load when the register is empty or its word leaves this cycle
   assign pop      = head.valid & (~valid_ff | rsp_ch.ready);
   assign valid_in = pop | (valid_ff & ~rsp_ch.ready);

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_byte   = out_ff.out_byte;
   assign rsp_ch.repeat_res = out_ff.repeat_res;
   assign rsp_ch.last       = out_ff.last;
   assign rsp_ch.error      = out_ff.error;

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= head.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/core/plane_rle_byte_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Plane RLE byte decoder, top level
// Decodes one run-length coded plane into (byte, repeat count) words.
// ----------------------------------------------------------------------------
// The decoder takes one coded byte per clock on req_ch and yields zero, one or
// two result words for it on rsp_ch; a run comes out as a single word with its
// repeat count, single and raw tail bytes with a count of one, and the word
// that completes the plane carries last. Results go through the queue and
// the output register. Input is taken whenever the four-entry result queue
// has two free slots, so the rate is one byte per clock as long as the sink
// takes a word per clock; the queue drains one word per clock, which bounds
// the rate only where bytes that yield two words come in long unbroken runs.
// A write on csr_ch (always ready) sets the plane size, saturated to 1048576,
// and restarts decoding; write it only with no words in flight. After an
// error word or the last word, bytes are taken and dropped until the next
// size write.
module plane_rle_byte_decoder_top import prd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   prd_req_if.sink   req_ch,
   prd_rsp_if.source rsp_ch,
   prd_csr_if.sink   csr_ch
);

   prd_push_type push;
   prd_head_type head;
   logic         room;
   logic         pop;

   prd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .room   (room),
      .push   (push)
   );

   prd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .pop   (pop),
      .head  (head)
   );

   prd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== tb/sv/plane_rle_byte_decoder_check.sv =====
// ----------------------------------------------------------------------------
// Plane RLE byte decoder checker
// Watches the coded byte, result and size channels, decodes every accepted
// coded byte on its own copy of the decoder state, and compares each accepted
// result word field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module plane_rle_byte_decoder_check import prd_pkg::*; (
   input  logic clock,
   input  logic reset,
   prd_req_if   req_ch,
   prd_rsp_if   rsp_ch,
   prd_csr_if   csr_ch,
   output int   fail_count,
   output int   words_pending,
   output int   word_count,
   output int   run_count,
   output int   error_count,
   output int   done_count
);
   timeunit 1ns;
   timeprecision 1ps;

   prd_phase_type     dec_phase;
   logic [BYTE_W-1:0] dec_held;
   logic [REP_W-1:0]  dec_left;
   logic [ACC_W-1:0]  dec_count;
   logic [SEEN_W-1:0] dec_count_idx;
   logic [REP_W-1:0]  plane_size;
   prd_result_type    expected_words[$];

   function automatic prd_result_type make_word(input logic [BYTE_W-1:0] b,
                                                input logic [REP_W-1:0] rep,
                                                input logic last_flag);
      prd_result_type w;
      w.out_byte   = b;
      w.repeat_res = rep;
      w.last       = last_flag;
      w.error      = 1'b0;
      return w;
   endfunction

   task automatic restart_plane();
      dec_held      = '0;
      dec_count     = '0;
      dec_count_idx = '0;
      dec_left      = plane_size;
      if (plane_size < RAW_LEFT) begin
         dec_phase = PH_BADSIZE;
      end else if (plane_size == RAW_LEFT) begin
         dec_phase = PH_RAW;
      end else begin
         dec_phase = PH_VALUE;
      end
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
      prd_result_type   w[2];
      int               n;
      logic [ACC_W-1:0] len;
      logic             run_end;
      n       = 0;
      run_end = 1'b0;
      len     = '0;
      case (dec_phase)
         PH_DONE, PH_FAILED: begin
            return;
         end
         PH_BADSIZE: begin
            dec_phase = PH_FAILED;
            expected_words.push_back(ERR_RESULT);
            return;
         end
         PH_VALUE: begin
            // five left: no lookahead, go straight to the raw tail
            if (dec_left == PRE_RAW_LEFT) begin
               w[0]      = make_word(b, REP_W'(1), 1'b0);
               n         = 1;
               dec_left  = RAW_LEFT;
               dec_phase = PH_RAW;
            end else begin
               dec_held  = b;
               dec_phase = PH_SECOND;
            end
         end
         PH_SECOND: begin
            if (b == dec_held) begin
               dec_phase = PH_LEN_SHORT;
            end else begin
               w[0]     = make_word(dec_held, REP_W'(1), 1'b0);
               n        = 1;
               dec_left = dec_left - REP_W'(1);
               if (dec_left == PRE_RAW_LEFT) begin
                  w[1]      = make_word(b, REP_W'(1), 1'b0);
                  n         = 2;
                  dec_left  = RAW_LEFT;
                  dec_phase = PH_RAW;
               end else begin
                  dec_held = b;
               end
            end
         end
         PH_LEN_SHORT: begin
            if (b != ESC_BYTE) begin
               len     = ACC_W'(b) + SHORT_BIAS;
               run_end = 1'b1;
            end else begin
               dec_count     = '0;
               dec_count_idx = '0;
               dec_phase     = PH_LEN_LONG;
            end
         end
         PH_LEN_LONG: begin
            dec_count = dec_count | (ACC_W'(b) << (8 * dec_count_idx));
            if (dec_count_idx == SEEN_LAST) begin
               dec_count_idx = '0;
               len           = dec_count;
               run_end       = 1'b1;
            end else begin
               dec_count_idx = dec_count_idx + 1'b1;
            end
         end
         default: begin
            dec_left = (dec_left - REP_W'(1)) & REP_W'(3);
            w[0]     = make_word(b, REP_W'(1), dec_left == '0);
            n        = 1;
            if (dec_left == '0) dec_phase = PH_DONE;
         end
      endcase

      if (run_end) begin
         if (len > ACC_W'(dec_left)) begin
            dec_phase = PH_FAILED;
            w[0]      = ERR_RESULT;
            n         = 1;
         end else begin
            if (len != '0) begin
               w[0] = make_word(dec_held, len[REP_W-1:0], 1'b0);
               n    = 1;
            end
            dec_left = dec_left - len[REP_W-1:0];
            if (dec_left > RAW_LEFT) begin
               dec_phase = PH_VALUE;
            end else if (dec_left == RAW_LEFT) begin
               dec_phase = PH_RAW;
            end else begin
               // raw tail cannot be formed
               dec_phase = PH_FAILED;
               w[0]      = ERR_RESULT;
               n         = 1;
            end
         end
      end

      // early final drops whatever this byte produced
      if (fin && dec_phase != PH_DONE && dec_phase != PH_FAILED) begin
         dec_phase = PH_FAILED;
         w[0]      = ERR_RESULT;
         n         = 1;
      end

      for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
   endtask

   task automatic check_word();
      prd_result_type got;
      prd_result_type want;
      got.out_byte   = rsp_ch.out_byte;
      got.repeat_res = rsp_ch.repeat_res;
      got.last       = rsp_ch.last;
      got.error      = rsp_ch.error;
      word_count++;
      if (got.error) error_count++;
      if (got.last) done_count++;
      if (!got.error && got.repeat_res > REP_W'(1)) run_count++;
      if (expected_words.size() == 0) begin
         $error("unexpected word: out_byte %0h repeat_res %0d last %0b error %0b",
                got.out_byte, got.repeat_res, got.last, got.error);
         fail_count++;
      end else begin
         want = expected_words.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            fail_count++;
         end
         if (got.repeat_res !== want.repeat_res) begin
            $error("repeat_res: expected %0d, got %0d", want.repeat_res, got.repeat_res);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fail_count++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, got.error);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         plane_size = RESET_SIZE;
         restart_plane();
         expected_words.delete();
      end else begin
         // words leaving now belong to bytes taken before this edge
         if (rsp_ch.valid && rsp_ch.ready) check_word();
         if (csr_ch.valid && csr_ch.ready) begin
            plane_size = (csr_ch.original_size > PLANE_BYTES_MAX) ? PLANE_BYTES_MAX
                                                                   : csr_ch.original_size;
            restart_plane();
         end
         if (req_ch.valid && req_ch.ready) decode_byte(req_ch.coded_byte, req_ch.final_req);
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== tb/sv/plane_rle_byte_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// Plane RLE byte decoder testbench
// Sets plane sizes, feeds directed and generated coded planes (well-formed
// planes with random content plus truncated, corrupted, overrunning and noise
// planes) with random gaps and result stalls, and reports the verdict from
// the checker's failure count and pending word count.
// ----------------------------------------------------------------------------
module plane_rle_byte_decoder_top_test import prd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int QUIET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1450;

   typedef enum int {
      FLAW_NONE,
      FLAW_TRUNC,
      FLAW_FLIP,
      FLAW_OVERRUN,
      FLAW_NOISE
   } plane_flaw_type;

   logic clock;
   logic reset;
   logic sink_ready = 1'b1;
   int   sink_hold  = 0;
   bit   tx_gaps_on = 1'b0;
   bit   rx_stalls_on = 1'b0;
   int   cycle_count = 0;

   int   fail_count;
   int   words_pending;
   int   word_count;
   int   run_count;
   int   error_count;
   int   done_count;

   logic [BYTE_W-1:0] plane_bytes[$];
   bit                plane_fins[$];

   prd_req_if req_ch ();
   prd_rsp_if rsp_ch ();
   prd_csr_if csr_ch ();

   assign rsp_ch.ready = sink_ready;

   plane_rle_byte_decoder_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   plane_rle_byte_decoder_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .word_count    (word_count),
      .run_count     (run_count),
      .error_count   (error_count),
      .done_count    (done_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[plane_rle_byte_decoder_top] ERROR");
         $finish;
      end
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      int g;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         g = 0;
      end else if (r < 85) begin
         g = $urandom_range(1, 3);
      end else if (r < 97) begin
         g = $urandom_range(4, 12);
      end else begin
         g = $urandom_range(20, 60);
      end
      return g;
   endfunction

   always @(negedge clock) begin
      if (sink_hold != 0) begin
         sink_hold  <= sink_hold - 1;
         sink_ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
         sink_hold  <= pick_gap();
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= 1'b1;
      end
   end

   function automatic logic [BYTE_W-1:0] pick_value(input bit ban_on,
                                                    input logic [BYTE_W-1:0] ban);
      int                r;
      logic [BYTE_W-1:0] v;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         v = 8'h00;
      end else if (r == 1) begin
         v = 8'hFF;
      end else begin
         v = 8'($urandom);
      end
      // a repeat of the held byte would turn a single into a run
      if (ban_on && v == ban) v = ~v;
      return v;
   endfunction

   function automatic logic [REP_W-1:0] pick_size();
      int               r;
      logic [REP_W-1:0] s;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         s = REP_W'($urandom_range(0, 3));
      end else if (r < 10) begin
         s = RAW_LEFT;
      end else if (r < 16) begin
         s = REP_W'($urandom_range(5, 6));
      end else if (r < 80) begin
         s = REP_W'($urandom_range(7, 64));
      end else if (r < 92) begin
         s = REP_W'($urandom_range(65, 2000));
      end else if (r < 97) begin
         s = REP_W'($urandom_range(2001, 1048576));
      end else if (r < 98) begin
         s = PLANE_BYTES_MAX;
      end else begin
         s = REP_W'($urandom_range(1048577, 21'h1FFFFF));
      end
      return s;
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] b, input bit fin);
      plane_bytes.push_back(b);
      plane_fins.push_back(fin);
   endtask

   task automatic push_run(input logic [BYTE_W-1:0] v, input logic [ACC_W-1:0] len,
                           input bit long_form);
      push_byte(v, 1'b0);
      push_byte(v, 1'b0);
      if (!long_form) begin
         push_byte(8'(len - SHORT_BIAS), 1'b0);
      end else begin
         push_byte(ESC_BYTE, 1'b0);
         for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8], 1'b0);
      end
   endtask

   task automatic build_plane(input logic [REP_W-1:0] size, input plane_flaw_type flaw);
      logic [REP_W-1:0]  left;
      logic [BYTE_W-1:0] v;
      logic [BYTE_W-1:0] ban;
      bit                ban_on;
      logic [ACC_W-1:0]  len;
      int                r;
      int                hi;
      int                pos;
      plane_bytes.delete();
      plane_fins.delete();
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(5, 40)) push_byte(8'($urandom), $urandom_range(0, 19) == 0);
         return;
      end
      if (size < RAW_LEFT) begin
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
         return;
      end
      left   = size;
      ban    = '0;
      ban_on = 1'b0;
      while (left > PRE_RAW_LEFT) begin
         v  = pick_value(ban_on, ban);
         hi = int'(left) - 4;
         if (flaw == FLAW_OVERRUN && $urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
               len = ACC_W'(hi + $urandom_range(1, 4));
            end else if (r == 1) begin
               len = ACC_W'(left) + ACC_W'($urandom_range(1, 300));
            end else begin
               len = '1;
            end
            push_run(v, len, len > 256 || $urandom_range(0, 1) == 1);
            return;
         end
         r = $urandom_range(0, 9);
         if ((left > 300 && r == 9) || (left <= 300 && r < 4)) begin
            push_byte(v, 1'b0);
            left   = left - REP_W'(1);
            ban    = v;
            ban_on = 1'b1;
         end else if ((left > 300 && r == 8) || (left <= 300 && r < 8)) begin
            len = ACC_W'($urandom_range(2, (hi > 256) ? 256 : hi));
            push_run(v, len, 1'b0);
            left   = left - len[REP_W-1:0];
            ban_on = 1'b0;
         end else begin
            r = $urandom_range(0, 7);
            if (r == 0) begin
               len = '0;
            end else if (r < 3) begin
               len = ACC_W'(hi);
            end else begin
               len = ACC_W'($urandom_range(0, hi));
            end
            push_run(v, len, 1'b1);
            left   = left - len[REP_W-1:0];
            ban_on = 1'b0;
         end
      end
      if (left == PRE_RAW_LEFT) push_byte(pick_value(ban_on, ban), 1'b0);
      repeat (3) push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), $urandom_range(0, 3) != 0);
      if (flaw == FLAW_TRUNC && plane_bytes.size() > 1) begin
         pos = $urandom_range(0, plane_bytes.size() - 2);
         plane_fins[pos] = 1'b1;
         while (plane_bytes.size() > pos + 1) begin
            void'(plane_bytes.pop_back());
            void'(plane_fins.pop_back());
         end
      end else if (flaw == FLAW_FLIP) begin
         pos = $urandom_range(0, plane_bytes.size() - 1);
         plane_bytes[pos] = 8'($urandom);
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.coded_byte <= b;
      req_ch.final_req  <= fin;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the sender until every expected word is out and the pipe is empty
   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [REP_W-1:0] v);
      @(negedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.original_size <= v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      int               bytes_sent;
      int               plane_total;
      int               r;
      logic [REP_W-1:0] size_w;
      logic [REP_W-1:0] size_eff;
      plane_flaw_type   flaw;
      bytes_sent           = 0;
      plane_total          = 0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.coded_byte    = '0;
      req_ch.final_req     = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.original_size = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plane of the reset size: raw tail only, then a dropped byte after completion
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h5A, 1'b0);
      wait_quiet();

      // size below four
      write_size('0);
      send_byte(8'h11, 1'b0);
      wait_quiet();

      // saturated size: zero-length run, longest run, raw tail
      write_size(21'h1FFFFF);
      push_run(8'hAA, '0, 1'b1);
      push_run(8'h3C, ACC_W'(PLANE_BYTES_MAX) - 4, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'hFE, 1'b1);
      foreach (plane_bytes[i]) send_byte(plane_bytes[i], plane_fins[i]);
      wait_quiet();

      while (bytes_sent < RANDOM_ITEMS) begin
         size_w   = pick_size();
         size_eff = (size_w > PLANE_BYTES_MAX) ? PLANE_BYTES_MAX : size_w;
         r        = $urandom_range(0, 99);
         if (r < 75) begin
            flaw = FLAW_NONE;
         end else if (r < 82) begin
            flaw = FLAW_TRUNC;
         end else if (r < 88) begin
            flaw = FLAW_FLIP;
         end else if (r < 94) begin
            flaw = FLAW_OVERRUN;
         end else begin
            flaw = FLAW_NOISE;
         end
         tx_gaps_on   = $urandom_range(0, 3) != 0;
         rx_stalls_on = $urandom_range(0, 3) != 0;
         write_size(size_w);
         build_plane(size_eff, flaw);
         foreach (plane_bytes[i]) begin
            send_byte(plane_bytes[i], plane_fins[i]);
            bytes_sent++;
         end
         // trailing bytes after a finished plane are dropped by the block
         if (flaw == FLAW_NONE && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom));
         end
         plane_total++;
         wait_quiet();
      end

      wait_quiet();
      $display("covered %0d generated planes, %0d coded bytes, %0d result words",
               plane_total, bytes_sent, word_count);
      $display("of which %0d runs, %0d error words, %0d completed planes",
               run_count, error_count, done_count);
      if (fail_count == 0 && words_pending == 0) begin
         $display("[plane_rle_byte_decoder_top] OK");
      end else begin
         $display("[plane_rle_byte_decoder_top] ERROR");
      end
      $finish;
   end

endmodule
